FILE: rtl/svtc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svtc_pkg
// Shared types and codes for the valve trial controller: phase and cause
// codes, configuration set and the packed per-tick result.
// ----------------------------------------------------------------------------
package svtc_pkg;

    // configuration register width and default tick counter width
    localparam int CFG_W          = 24;
    localparam int DEF_TICK_W     = 24;
    localparam int PADDR_W        = 4;
    localparam int PDATA_W        = 32;
    localparam int S_TDATA_W      = 8;
    localparam int M_TDATA_W      = 16;

    // phase codes
    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_TRIAL = 2'd1;
    localparam logic [1:0] PH_HOLD  = 2'd2;

    // change cause codes
    localparam logic [2:0] WHY_BOOT    = 3'd0;
    localparam logic [2:0] WHY_OFF     = 3'd1;
    localparam logic [2:0] WHY_SCHED   = 3'd2;
    localparam logic [2:0] WHY_KEEP    = 3'd3;
    localparam logic [2:0] WHY_TIMEOUT = 3'd4;
    localparam logic [2:0] WHY_MAXHOLD = 3'd5;

    // register indexes on the configuration port
    localparam logic [1:0] REG_MIN_CLOSED   = 2'd0;
    localparam logic [1:0] REG_TRIAL_WINDOW = 2'd1;
    localparam logic [1:0] REG_MAX_HOLD     = 2'd2;

    typedef struct packed {
        logic [CFG_W-1:0] max_hold_ticks;
        logic [CFG_W-1:0] trial_window_ticks;
        logic [CFG_W-1:0] min_closed_ticks;
    } cfg_t;

    // declared highest field first so valve_level lands in bit 0
    typedef struct packed {
        logic       max_hold_warn;
        logic       stray_keep_open;
        logic [2:0] cause;
        logic [1:0] phase;
        logic       changed;
        logic       close_pulse;
        logic       open_pulse;
        logic       valve_level;
    } result_t;

    localparam int RESULT_W = $bits(result_t);

endpackage

FILE: rtl/svtc_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svtc_step
// Next-state and result logic for one tick: phase decision, tick count
// update with saturation, cause tracking and relay pulses.
// ----------------------------------------------------------------------------
module svtc_step #(
    parameter int TICK_W = svtc_pkg::DEF_TICK_W
) (
    input  logic [1:0]          cur_phase,
    input  logic [TICK_W-1:0]   ticks,
    input  logic [2:0]          last_cause,
    input  logic                due_flag,
    input  logic                keep_open_req,
    input  logic                turn_off_req,
    input  svtc_pkg::cfg_t      cfg,
    output logic [1:0]          next_phase,
    output logic [TICK_W-1:0]   next_ticks,
    output logic [2:0]          next_cause,
    output svtc_pkg::result_t   result
);
    import svtc_pkg::*;

    localparam int CMP_W = (TICK_W > CFG_W) ? TICK_W : CFG_W;

    logic [1:0]       ph;
    logic [CMP_W-1:0] t_ext;
    logic             min_closed_done;
    logic             window_done;
    logic             hold_done;
    logic             stray;
    logic             maxwarn;
    logic             chg;
    logic             open_before;
    logic             now_open;

    // threshold compares on the count before this tick
    assign t_ext           = CMP_W'(ticks);
    assign min_closed_done = t_ext >= CMP_W'(cfg.min_closed_ticks);
    assign window_done     = t_ext >= CMP_W'(cfg.trial_window_ticks);
    assign hold_done       = t_ext >= CMP_W'(cfg.max_hold_ticks);

    // unused phase code behaves as holding
    assign ph = (cur_phase == 2'd3) ? PH_HOLD : cur_phase;

    // phase decision
    always_comb
    begin
        next_phase = ph;
        next_cause = last_cause;
        stray      = 1'b0;
        maxwarn    = 1'b0;
        if (turn_off_req && ph != PH_IDLE)
        begin
            next_phase = PH_IDLE;
            next_cause = WHY_OFF;
        end
        else
        begin
            case (ph)
                PH_IDLE:
                begin
                    stray = keep_open_req;
                    if (min_closed_done && due_flag)
                    begin
                        next_phase = PH_TRIAL;
                        next_cause = WHY_SCHED;
                    end
                end
                PH_TRIAL:
                begin
                    if (keep_open_req)
                    begin
                        next_phase = PH_HOLD;
                        next_cause = WHY_KEEP;
                    end
                    else if (window_done)
                    begin
                        next_phase = PH_IDLE;
                        next_cause = WHY_TIMEOUT;
                    end
                end
                default:
                begin
                    if (hold_done)
                    begin
                        next_phase = PH_IDLE;
                        next_cause = WHY_MAXHOLD;
                        maxwarn    = 1'b1;
                    end
                end
            endcase
        end
    end

    assign open_before = ph != PH_IDLE;
    assign now_open    = next_phase != PH_IDLE;
    assign chg         = next_phase != ph;

    // tick count: restart on change, else count up and saturate
    always_comb
    begin
        if (chg)
            next_ticks = TICK_W'(1);
        else if (ticks != {TICK_W{1'b1}})
            next_ticks = ticks + TICK_W'(1);
        else
            next_ticks = ticks;
    end

    // per-tick result
    always_comb
    begin
        result.valve_level     = now_open;
        result.open_pulse      = chg && now_open && !open_before;
        result.close_pulse     = chg && !now_open && open_before;
        result.changed         = chg;
        result.phase           = next_phase;
        result.cause           = next_cause;
        result.stray_keep_open = stray;
        result.max_hold_warn   = maxwarn;
    end

endmodule

FILE: rtl/svtc_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svtc_cfg
// Configuration register file on an APB-style port: three 24-bit tick
// thresholds, written on the access phase and read back.
// ----------------------------------------------------------------------------
module svtc_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [svtc_pkg::PADDR_W-1:0]    paddr,
    input  logic [svtc_pkg::PDATA_W-1:0]    pwdata,
    output logic [svtc_pkg::PDATA_W-1:0]    prdata,
    output logic                            pready,
    output svtc_pkg::cfg_t                  cfg
);
    import svtc_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [1:0] reg_idx;
    logic       wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;

    // write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_MIN_CLOSED:   cfg_next.min_closed_ticks   = pwdata[CFG_W-1:0];
                REG_TRIAL_WINDOW: cfg_next.trial_window_ticks = pwdata[CFG_W-1:0];
                REG_MAX_HOLD:     cfg_next.max_hold_ticks     = pwdata[CFG_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else
            cfg_reg <= cfg_next;
    end

    // read mux
    always_comb
    begin
        unique case (reg_idx)
            REG_MIN_CLOSED:   prdata = PDATA_W'(cfg_reg.min_closed_ticks);
            REG_TRIAL_WINDOW: prdata = PDATA_W'(cfg_reg.trial_window_ticks);
            REG_MAX_HOLD:     prdata = PDATA_W'(cfg_reg.max_hold_ticks);
            default:          prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

FILE: rtl/scheduled_valve_trial_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scheduled_valve_trial_controller
// Three-phase valve controller (idle, trial, holding) driven by tick items,
// with a saturating tick counter and per-tick relay and status result.
//
//   channel  | dir | handshake               | payload
//   ---------+-----+-------------------------+--------------------------------
//   s_*      | in  | s_tvalid / s_tready     | s_tdata: tick flags
//   m_*      | out | m_tvalid / m_tready     | m_tdata: tick result
//   apb      | in  | psel, penable, pready   | paddr, pwdata, prdata: thresholds
//
// One tick per cycle sustained while m_tready stays high; a tick's result
// goes from the input register through the step logic into the result
// register, from which it transfers out on m_tdata.
// The phase/count/cause registers update when a tick moves into the result
// register, so the next tick sees them the following cycle.
// Reset: idle phase, count 0, cause boot, thresholds 0, both stages empty.
// A stalled m_tready holds the result; the input register still takes one
// more tick before s_tready drops.
// ----------------------------------------------------------------------------
module scheduled_valve_trial_controller #(
    parameter int TICK_COUNT_WIDTH = svtc_pkg::DEF_TICK_W
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // due_flag[0], keep_open_req[1], turn_off_req[2], zeros[7:3]
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [svtc_pkg::S_TDATA_W-1:0]  s_tdata,
    // valve_level[0], open_pulse[1], close_pulse[2], changed[3], phase[5:4],
    // cause[8:6], stray_keep_open[9], max_hold_warn[10], zeros[15:11]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [svtc_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [svtc_pkg::PADDR_W-1:0]    paddr,
    input  logic [svtc_pkg::PDATA_W-1:0]    pwdata,
    output logic [svtc_pkg::PDATA_W-1:0]    prdata,
    output logic                            pready
);
    import svtc_pkg::*;

    cfg_t                       cfg;

    logic                       in_valid_reg;
    logic [2:0]                 in_flags_reg;
    logic                       out_valid_reg;
    result_t                    out_result_reg;
    result_t                    step_result;

    logic [1:0]                 phase_reg;
    logic [1:0]                 phase_next;
    logic [TICK_COUNT_WIDTH-1:0] ticks_reg;
    logic [TICK_COUNT_WIDTH-1:0] ticks_next;
    logic [2:0]                 cause_reg;
    logic [2:0]                 cause_next;

    logic                       out_free;
    logic                       step_fire;
    logic                       in_take;

    // configuration registers
    svtc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // stage flow control
    assign out_free  = !out_valid_reg || m_tready;
    assign step_fire = in_valid_reg && out_free;
    assign s_tready  = !in_valid_reg || step_fire;
    assign in_take   = s_tvalid && s_tready;

    // tick step logic
    svtc_step #(
        .TICK_W (TICK_COUNT_WIDTH)
    ) u_step (
        .cur_phase     (phase_reg),
        .ticks         (ticks_reg),
        .last_cause    (cause_reg),
        .due_flag      (in_flags_reg[0]),
        .keep_open_req (in_flags_reg[1]),
        .turn_off_req  (in_flags_reg[2]),
        .cfg           (cfg),
        .next_phase    (phase_next),
        .next_ticks    (ticks_next),
        .next_cause    (cause_next),
        .result        (step_result)
    );

    // control state: stage valids and controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_IDLE;
            ticks_reg     <= '0;
            cause_reg     <= WHY_BOOT;
        end
        else
        begin
            if (in_take)
                in_valid_reg <= 1'b1;
            else if (step_fire)
                in_valid_reg <= 1'b0;

            if (step_fire)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;

            if (step_fire)
            begin
                phase_reg <= phase_next;
                ticks_reg <= ticks_next;
                cause_reg <= cause_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
            in_flags_reg <= s_tdata[2:0];
        if (step_fire)
            out_result_reg <= step_result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'(out_result_reg);

endmodule

FILE: rtl/svtc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svtc_checker
// Port-level checks for the valve trial controller, bound to the top level.
// ----------------------------------------------------------------------------
module svtc_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [svtc_pkg::M_TDATA_W-1:0]  m_tdata
);
    import svtc_pkg::*;

    result_t res;
    assign res = result_t'(m_tdata[RESULT_W-1:0]);

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // open pulse only on a scheduled entry into trial
    a_open: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && res.open_pulse |->
            res.changed && res.valve_level && res.phase == PH_TRIAL &&
            res.cause == WHY_SCHED)
        else $error("open pulse without scheduled trial entry");

    // close pulse only on a change to idle
    a_close: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && res.close_pulse |->
            res.changed && !res.valve_level && res.phase == PH_IDLE &&
            !res.open_pulse)
        else $error("close pulse without change to idle");

    // max hold warning comes with a forced close
    a_maxhold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && res.max_hold_warn |->
            res.close_pulse && res.cause == WHY_MAXHOLD && !res.stray_keep_open)
        else $error("max hold warning without forced close");

endmodule

bind scheduled_valve_trial_controller svtc_checker u_svtc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the valve trial controller. A scoreboard class
// predicts the per-tick result (phase, relay pulses, cause, warnings) from
// every accepted tick and checks each result transfer against it. Directed
// ticks cover each phase change and the odd corners. Saturation runs use a
// narrow tick counter against large thresholds. Random phases then run with
// fresh thresholds, idle cycles on both streams and one long output stall.
// ----------------------------------------------------------------------------
module tb;

    import svtc_pkg::*;

    // narrow counter so saturation is reachable in a short run
    localparam int              TICK_W          = 8;
    localparam longint unsigned TICK_MAX        = (64'd1 << TICK_W) - 1;
    localparam int              HOLD_OFF_CYCLES = 64;
    localparam int              DRAIN_CYCLES    = 4;
    localparam int              CYCLE_LIMIT     = 200000;

    // tick prediction and result checking
    class valve_scoreboard;
        logic [CFG_W-1:0] min_closed;
        logic [CFG_W-1:0] trial_window;
        logic [CFG_W-1:0] hold_limit;
        logic [1:0]       phase_q;
        longint unsigned  ticks_q;
        logic [2:0]       cause_q;
        result_t          expected_q[$];
        int               errors;
        int               ticks_seen;
        int               results_seen;
        int               strays;
        int               saturations;
        int               changes_by_cause[6];

        function new();
            min_closed   = '0;
            trial_window = '0;
            hold_limit   = '0;
            phase_q      = PH_IDLE;
            ticks_q      = 0;
            cause_q      = WHY_BOOT;
            errors       = 0;
            ticks_seen   = 0;
            results_seen = 0;
            strays       = 0;
            saturations  = 0;
            foreach (changes_by_cause[i]) changes_by_cause[i] = 0;
        endfunction

        function void set_threshold(input logic [1:0] idx, input logic [CFG_W-1:0] value);
            case (idx)
                REG_MIN_CLOSED:   min_closed   = value;
                REG_TRIAL_WINDOW: trial_window = value;
                REG_MAX_HOLD:     hold_limit   = value;
                default:          ;
            endcase
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // step the phase machine for one accepted tick
        function void note_tick(input logic [S_TDATA_W-1:0] word);
            logic            due;
            logic            keep;
            logic            off;
            logic [1:0]      cur;
            logic [1:0]      nxt;
            longint unsigned t;
            result_t         r;
            due  = word[0];
            keep = word[1];
            off  = word[2];
            cur  = (phase_q == 2'd3) ? PH_HOLD : phase_q;
            nxt  = cur;
            t    = ticks_q;
            r    = '0;
            ticks_seen++;
            if (off && cur != PH_IDLE)
            begin
                nxt     = PH_IDLE;
                cause_q = WHY_OFF;
            end
            else if (cur == PH_IDLE)
            begin
                r.stray_keep_open = keep;
                if (due && t >= min_closed)
                begin
                    nxt     = PH_TRIAL;
                    cause_q = WHY_SCHED;
                end
            end
            else if (cur == PH_TRIAL)
            begin
                if (keep)
                begin
                    nxt     = PH_HOLD;
                    cause_q = WHY_KEEP;
                end
                else if (t >= trial_window)
                begin
                    nxt     = PH_IDLE;
                    cause_q = WHY_TIMEOUT;
                end
            end
            else if (t >= hold_limit)
            begin
                nxt             = PH_IDLE;
                cause_q         = WHY_MAXHOLD;
                r.max_hold_warn = 1'b1;
            end
            r.changed = (nxt != cur);
            // count restarts on a change, otherwise counts up and sticks at its top
            if (r.changed)
            begin
                ticks_q = 1;
                changes_by_cause[cause_q]++;
            end
            else if (ticks_q < TICK_MAX)
            begin
                ticks_q++;
            end
            else
            begin
                saturations++;
            end
            if (r.stray_keep_open) strays++;
            phase_q       = nxt;
            r.valve_level = (nxt != PH_IDLE);
            r.open_pulse  = r.changed && (cur == PH_IDLE);
            r.close_pulse = r.changed && (nxt == PH_IDLE);
            r.phase       = nxt;
            r.cause       = cause_q;
            expected_q.push_back(r);
        endfunction

        function void compare_field(input string name, input int unsigned want,
                                    input int unsigned got);
            if (want != got)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            end
        endfunction

        // compare one result transfer with the oldest prediction
        function void check_result(input logic [M_TDATA_W-1:0] word);
            result_t got;
            result_t want;
            got = word[RESULT_W-1:0];
            if (expected_q.size() == 0)
            begin
                errors++;
                $display("%0t: result %h with no tick pending, expected none, actual %h",
                         $time, word, word);
                return;
            end
            want = expected_q.pop_front();
            results_seen++;
            compare_field("valve_level", want.valve_level, got.valve_level);
            compare_field("open_pulse", want.open_pulse, got.open_pulse);
            compare_field("close_pulse", want.close_pulse, got.close_pulse);
            compare_field("changed", want.changed, got.changed);
            compare_field("phase", want.phase, got.phase);
            compare_field("cause", want.cause, got.cause);
            compare_field("stray_keep_open", want.stray_keep_open, got.stray_keep_open);
            compare_field("max_hold_warn", want.max_hold_warn, got.max_hold_warn);
            compare_field("tdata padding", 0, word[M_TDATA_W-1:RESULT_W]);
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    // due_flag[0], keep_open_req[1], turn_off_req[2], zeros[7:3]
    logic [S_TDATA_W-1:0]   s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    // valve_level[0], open_pulse[1], close_pulse[2], changed[3], phase[5:4],
    // cause[8:6], stray_keep_open[9], max_hold_warn[10], zeros[15:11]
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [PADDR_W-1:0]     paddr;
    logic [PDATA_W-1:0]     pwdata;
    logic [PDATA_W-1:0]     prdata;
    logic                   pready;

    valve_scoreboard        sb;
    bit                     no_idle;
    bit                     hold_off_go;
    int                     cycle_count;
    int                     cfg_count;

    scheduled_valve_trial_controller #(
        .TICK_COUNT_WIDTH(TICK_W)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // cycle counter and run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("%0t: run limit of %0d cycles reached", $time, CYCLE_LIMIT);
        $display("** scheduled_valve_trial_controller: FAILED **");
        $finish;
    end

    function automatic bit take_gap();
        return !no_idle && ($urandom_range(99) < 32);
    endfunction

    function automatic bit roll(input int pct);
        return $urandom_range(99) < pct;
    endfunction

    // watch both streams at each edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready) sb.note_tick(s_tdata);
            if (m_tvalid && m_tready) sb.check_result(m_tdata);
        end
    end

    // result side: random backpressure, plus one long hold-off on request
    initial
    begin
        int n;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_go)
            begin
                m_tready <= 1'b0;
                for (n = 0; n < HOLD_OFF_CYCLES; n++) @(posedge clk);
                hold_off_go = 1'b0;
            end
            else
            begin
                m_tready <= !take_gap();
            end
        end
    end

    // offer one tick and wait for its transfer
    task automatic send_tick(input logic due, input logic keep, input logic off);
        while (take_gap())
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W-3){1'b0}}, off, keep, due};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    task automatic run_random(input int count, input int due_pct, input int keep_pct,
                              input int off_pct);
        int i;
        for (i = 0; i < count; i++) send_tick(roll(due_pct), roll(keep_pct), roll(off_pct));
    endtask

    // stop offering and wait for every predicted result
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // write one threshold, then read it back
    task automatic program_reg(input logic [1:0] idx, input logic [CFG_W-1:0] value);
        logic [PDATA_W-1:0] readback;
        // upper bits carry junk the register must drop
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {8'($urandom), value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_threshold(idx, value);
        @(posedge clk);
        psel    <= 1'b1;
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        readback = prdata;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (readback !== {{(PDATA_W-CFG_W){1'b0}}, value})
        begin
            sb.errors++;
            $display("%0t: register %0d readback, expected %h, actual %h",
                     $time, idx, value, readback);
        end
    endtask

    task automatic apply_cfg(input logic [CFG_W-1:0] min_closed,
                             input logic [CFG_W-1:0] trial_window,
                             input logic [CFG_W-1:0] hold_limit);
        drain();
        program_reg(REG_MIN_CLOSED, min_closed);
        program_reg(REG_TRIAL_WINDOW, trial_window);
        program_reg(REG_MAX_HOLD, hold_limit);
        cfg_count++;
    endtask

    // stimulus
    initial
    begin
        int ph;
        sb          = new();
        cycle_count = 0;
        cfg_count   = 0;
        no_idle     = 1'b0;
        hold_off_go = 1'b0;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, thresholds at reset value zero
        send_tick(1'b0, 1'b0, 1'b0);    // idle, nothing due
        send_tick(1'b0, 1'b0, 1'b1);    // turn-off while idle does nothing
        send_tick(1'b0, 1'b1, 1'b0);    // stray keep-open
        send_tick(1'b1, 1'b1, 1'b1);    // all flags in idle: opens, stray
        send_tick(1'b0, 1'b1, 1'b1);    // turn-off beats keep-open in trial
        send_tick(1'b1, 1'b0, 1'b0);    // open a trial
        send_tick(1'b0, 1'b1, 1'b0);    // trial to holding, no pulse
        send_tick(1'b0, 1'b1, 1'b0);    // holding ends on max hold
        send_tick(1'b1, 1'b0, 1'b0);
        send_tick(1'b0, 1'b0, 1'b0);    // trial times out
        send_tick(1'b1, 1'b0, 1'b0);
        send_tick(1'b0, 1'b1, 1'b0);
        send_tick(1'b0, 1'b0, 1'b1);    // turn-off from holding

        // directed, small thresholds
        apply_cfg(24'd2, 24'd1, 24'd3);
        send_tick(1'b1, 1'b0, 1'b0);
        send_tick(1'b1, 1'b0, 1'b0);
        send_tick(1'b1, 1'b1, 1'b0);
        send_tick(1'b0, 1'b1, 1'b0);
        repeat (4) send_tick(1'b0, 1'b0, 1'b0);
        send_tick(1'b0, 1'b1, 1'b0);    // stray keep-open, closed time met but nothing due
        send_tick(1'b1, 1'b0, 1'b0);
        send_tick(1'b1, 1'b0, 1'b0);
        repeat (3) send_tick(1'b0, 1'b0, 1'b0);

        // thresholds out of the counter's reach: stays idle, count saturates
        apply_cfg(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        run_random(270, 50, 30, 10);

        // long holding and long trial, both saturate until turned off
        apply_cfg(24'd0, 24'hFFFFFF, 24'hFFFFFF);
        send_tick(1'b1, 1'b0, 1'b0);
        send_tick(1'b0, 1'b1, 1'b0);
        run_random(260, 50, 30, 0);
        send_tick(1'b0, 1'b0, 1'b1);
        send_tick(1'b1, 1'b0, 1'b0);
        run_random(260, 50, 0, 0);
        send_tick(1'b0, 1'b0, 1'b1);

        // thresholds equal to the saturated count
        apply_cfg(24'(TICK_MAX), 24'(TICK_MAX), 24'(TICK_MAX));
        run_random(400, 70, 1, 0);

        // random phases with fresh small thresholds
        for (ph = 0; ph < 5; ph++)
        begin
            apply_cfg(24'($urandom_range(7)), 24'($urandom_range(7)),
                      24'($urandom_range(9)));
            if (ph == 2)
            begin
                // no idling, and the result side holds off to fill the block
                no_idle     = 1'b1;
                hold_off_go = 1'b1;
            end
            run_random(50, 30 + 10 * ph, 30, (ph == 4) ? 25 : 6);
            no_idle = 1'b0;
        end

        drain();
        $display("covered %0d ticks, %0d results, %0d threshold sets;",
                 sb.ticks_seen, sb.results_seen, cfg_count);
        $display("  %0d stray keep-opens, %0d saturated ticks, changes: sched %0d, keep %0d,",
                 sb.strays, sb.saturations, sb.changes_by_cause[WHY_SCHED],
                 sb.changes_by_cause[WHY_KEEP]);
        $display("  timeout %0d, max hold %0d, turn-off %0d",
                 sb.changes_by_cause[WHY_TIMEOUT], sb.changes_by_cause[WHY_MAXHOLD],
                 sb.changes_by_cause[WHY_OFF]);
        if (sb.errors == 0 && sb.pending() == 0)
        begin
            $display("** scheduled_valve_trial_controller: PASSED **");
        end
        else
        begin
            $display("** scheduled_valve_trial_controller: FAILED **");
        end
        $finish;
    end

endmodule
